>>> design/tcwc_pkg.sv
package tcwc_pkg;

  localparam int unsigned SEQ_BITS   = 32;
  localparam int unsigned MAX_WINDOW = 65535;
  localparam int unsigned WIN_BITS   = 16;
  localparam int unsigned NUM_BITS   = 32;

  localparam int unsigned IN_DATA_BITS  = 64;
  localparam int unsigned OUT_DATA_BITS = 120;

  typedef enum logic [2:0] {
    ACT_SEND     = 3'd0,
    ACT_CUM_ACK  = 3'd1,
    ACT_ACK_PKT  = 3'd2,
    ACT_DATA_RX  = 3'd3,
    ACT_TIMEOUT  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_NOT_HELD = 2'd2
  } status_e;

  typedef struct packed {
    logic [WIN_BITS-1:0] window;
    logic [WIN_BITS-1:0] threshold;
    logic                avoid;
    logic [SEQ_BITS-1:0] seq_next;
    logic [SEQ_BITS-1:0] oldest;
    logic [SEQ_BITS-1:0] expected;
  } cc_state_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [NUM_BITS-1:0] assigned_seq;
    logic [NUM_BITS-1:0] ack_value;
    logic [WIN_BITS-1:0] window_now;
    logic [WIN_BITS-1:0] threshold_now;
    logic                in_avoidance;
    logic [WIN_BITS-1:0] outstanding;
  } cc_result_t;

endpackage

>>> design/tcwc_update.sv
module tcwc_update import tcwc_pkg::*; (
  input  cc_state_t           state_i,
  input  logic [2:0]          action_i,
  input  logic [NUM_BITS-1:0] ack_number_i,
  input  logic [NUM_BITS-1:0] retransmit_seq_i,
  output cc_state_t           state_o,
  output cc_result_t          result_o
);

  localparam logic [WIN_BITS:0] MaxWin = (WIN_BITS+1)'(MAX_WINDOW);

  logic [SEQ_BITS-1:0] held;
  logic [SEQ_BITS-1:0] held_n;
  logic [SEQ_BITS-1:0] win_ext;
  logic [SEQ_BITS-1:0] rdiff;
  logic [NUM_BITS-1:0] ack_sel;
  logic [WIN_BITS:0]   dbl;
  logic [WIN_BITS-1:0] half;
  logic                wrapped;
  logic                below_end;
  logic                rseq_in_space;
  logic                is_ack;
  cc_state_t           nxt;
  logic [1:0]          status;
  logic [NUM_BITS-1:0] assigned;

  assign held          = state_i.seq_next - state_i.oldest;
  assign win_ext       = SEQ_BITS'(state_i.window);
  assign ack_sel       = (action_i == ACT_CUM_ACK) ? ack_number_i : NUM_BITS'(state_i.expected);
  assign wrapped       = state_i.seq_next < state_i.oldest;
  assign below_end     = wrapped ? ((ack_sel >> SEQ_BITS) == '0)
                                 : (ack_sel < NUM_BITS'(state_i.seq_next));
  assign rseq_in_space = (retransmit_seq_i >> SEQ_BITS) == '0;
  assign rdiff         = retransmit_seq_i[SEQ_BITS-1:0] - state_i.oldest;
  assign dbl           = {state_i.window, 1'b0};
  assign half          = state_i.window >> 1;
  assign is_ack        = (action_i == ACT_CUM_ACK) || (action_i == ACT_ACK_PKT);

  always_comb begin
    nxt      = state_i;
    status   = ST_DONE;
    assigned = '0;
    if (is_ack) begin
      if (held != '0 && ack_sel > NUM_BITS'(state_i.oldest)) begin
        nxt.oldest = below_end ? ack_sel[SEQ_BITS-1:0] : state_i.seq_next;
      end
      if (!state_i.avoid) begin
        nxt.window = (dbl > MaxWin) ? MaxWin[WIN_BITS-1:0] : dbl[WIN_BITS-1:0];
        if (nxt.window >= state_i.threshold) begin
          nxt.avoid = 1'b1;
        end
      end else if ((WIN_BITS+1)'(state_i.window) < MaxWin) begin
        nxt.window = state_i.window + 1'b1;
      end
    end
    case (action_i)
      ACT_SEND: begin
        if (held >= win_ext) begin
          status = ST_BLOCKED;
        end else begin
          assigned     = NUM_BITS'(state_i.seq_next);
          nxt.seq_next = state_i.seq_next + 1'b1;
        end
      end
      ACT_DATA_RX: begin
        if (state_i.seq_next > state_i.expected) begin
          nxt.expected = state_i.seq_next;
        end
      end
      ACT_TIMEOUT: begin
        if (rseq_in_space && rdiff < held) begin
          nxt.threshold = (half == '0) ? WIN_BITS'(1) : half;
          nxt.window    = WIN_BITS'(1);
          nxt.avoid     = 1'b0;
        end else begin
          status = ST_NOT_HELD;
        end
      end
      default: ;
    endcase
  end

  assign held_n  = nxt.seq_next - nxt.oldest;
  assign state_o = nxt;

  assign result_o.status        = status;
  assign result_o.assigned_seq  = assigned;
  assign result_o.ack_value     = NUM_BITS'(nxt.expected);
  assign result_o.window_now    = nxt.window;
  assign result_o.threshold_now = nxt.threshold;
  assign result_o.in_avoidance  = nxt.avoid;
  assign result_o.outstanding   = held_n[WIN_BITS-1:0];

endmodule

>>> design/tcp_congestion_window_control.sv
// Sender-side congestion-window engine: each transfer in carries one event
// (send, cumulative ACK, ACK packet, data receipt, timeout retransmit) and
// yields exactly one result transfer with the status, the sequence number
// given to a send, and the window, threshold, mode and outstanding count after
// the event. An event lands in an input register, is resolved against the
// window state by one pass of compare, shift and increment logic, and moves
// to an output register. One event is taken per cycle while the output is
// drained; a stalled output holds both registers until it is drained.
module tcp_congestion_window_control import tcwc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // ack_number [31:0], retransmit_seq [63:32]
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // action [2:0]
  input  logic [2:0]               s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // assigned_seq [31:0], ack_value [63:32], window_now [79:64],
  // threshold_now [95:80], in_avoidance [96], outstanding [112:97], zero [119:113]
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]               m_axis_tuser
);

  logic                in_valid_q;
  logic [2:0]          action_q;
  logic [NUM_BITS-1:0] ack_q;
  logic [NUM_BITS-1:0] rseq_q;
  logic                out_valid_q;
  cc_result_t          res_q;
  cc_result_t          res_d;
  cc_state_t           st_q;
  cc_state_t           st_d;
  logic                adv;
  logic                take;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  tcwc_update u_update (
    .state_i          (st_q),
    .action_i         (action_q),
    .ack_number_i     (ack_q),
    .retransmit_seq_i (rseq_q),
    .state_o          (st_d),
    .result_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      st_q.window    <= WIN_BITS'(1);
      st_q.threshold <= WIN_BITS'(16);
      st_q.avoid     <= 1'b0;
      st_q.seq_next  <= SEQ_BITS'(1);
      st_q.oldest    <= SEQ_BITS'(1);
      st_q.expected  <= SEQ_BITS'(1);
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          st_q <= st_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      action_q <= s_axis_tuser;
      ack_q    <= s_axis_tdata[NUM_BITS-1:0];
      rseq_q   <= s_axis_tdata[2*NUM_BITS-1:NUM_BITS];
    end
    if (adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {7'd0, res_q.outstanding, res_q.in_avoidance, res_q.threshold_now,
                          res_q.window_now, res_q.ack_value, res_q.assigned_seq};

  a_window_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.window != '0 && st_q.threshold != '0)
    else $error("window or threshold reached zero");

  a_move_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && adv |=> out_valid_q)
    else $error("event lost between input and output register");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_q && adv) |=> $stable(st_q))
    else $error("state changed without an event");

  a_blocked_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == ST_BLOCKED |-> res_q.outstanding >= res_q.window_now)
    else $error("send blocked while window open");

endmodule
